// ===== rtl/core/peer_table_with_aging_macros.svh =====
// Assertion helpers for the peer table checker.
`ifndef PEER_TABLE_WITH_AGING_MACROS_SVH
`define PEER_TABLE_WITH_AGING_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PTWA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptwa: same-cycle property failed");

// Next-cycle implication, disabled while in reset.
`define PTWA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptwa: next-cycle property failed");

`endif

// ===== rtl/core/ptwa_pkg.sv =====
package ptwa_pkg;

  localparam int unsigned TABLE_SLOTS     = 4;
  localparam int unsigned HELLO_MIN_BYTES = 15;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);

  localparam int unsigned OP_W        = 2;
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned HEAD_W      = 64;
  localparam int unsigned TAIL_W      = 24;
  localparam int unsigned NAME_W      = HEAD_W + TAIL_W;
  localparam int unsigned NAME_CHARS  = NAME_W / BYTE_W;
  localparam int unsigned ENTRY_IDX_W = 2;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned TOTAL_W     = 3;
  localparam int unsigned SLOT_W      = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd15000;
  localparam logic [BYTE_W-1:0] ROLE_RESET    = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLE    = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_HELLO = 2'd0,
    OP_PONG  = 2'd1,
    OP_QUERY = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_e;

  // Classified command, front to back
  typedef struct packed {
    op_e                    op;
    logic [ADDR_W-1:0]      addr;
    logic [TIME_W-1:0]      now;
    logic                   hello_ok;
    logic [HEAD_W-1:0]      name_head;
    logic [TAIL_W-1:0]      name_tail;
    logic [BYTE_W-1:0]      cap5;
    logic [BYTE_W-1:0]      caplr;
    logic [ENTRY_IDX_W-1:0] ridx;
  } cmd_t;

  // One result item
  typedef struct packed {
    status_e            status;
    logic [TOTAL_W-1:0] total;
    logic [SLOT_W-1:0]  slot;
    logic [TIME_W-1:0]  age;
    logic [ADDR_W-1:0]  addr;
    logic [HEAD_W-1:0]  name_head;
    logic [TAIL_W-1:0]  name_tail;
    logic [BYTE_W-1:0]  cap5;
    logic [BYTE_W-1:0]  caplr;
    logic [TIME_W-1:0]  seen;
  } res_t;

  // Zero every character from the first null onward
  function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              ended;
    res = '0;
    for (int k = 0; k < NAME_CHARS; k++) begin
      ended = 1'b0;
      for (int j = 0; j <= k; j++) begin
        ended = ended | (raw[j*BYTE_W +: BYTE_W] == '0);
      end
      res[k*BYTE_W +: BYTE_W] = ended ? '0 : raw[k*BYTE_W +: BYTE_W];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/peer_table_with_aging.sv =====
// Peer table with aging: up to four peers keyed by a 48-bit address.
// Input channel (in_valid_i / in_ready_o) carries one command item per
// handshake: hello, pong, evict-and-query or read. Output channel
// (out_valid_o / out_ready_i) returns exactly one result item per command,
// in order. Config writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect
// at the clock edge; write them only while the block is idle.
// Steps: hello, pong and read pass through queue pop, execute and output
// load. A query walks the occupied slots downward, takes one copy step per
// eviction and then scans the survivors plus one final step. Throughput is
// one item per back-end pass, as the back end takes a new command only
// when idle; this is set by the single read port of the peer store and the
// walk sequencer.
// A two-item command queue sits between the front classifier and the back
// sequencer, so items are still accepted while a result waits.
// Reset clears the peer count, the queue and the output valid; stored
// entries are left as they are. Timeout resets to 15000 ms, role to 1.
// A stalled receiver holds the result steady; the back end then stalls
// and the input stalls once the queue fills.
module peer_table_with_aging #(
  parameter int unsigned QUEUE_DEPTH = ptwa_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config
  input  logic                                 cfg_we_i,
  input  logic [ptwa_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ptwa_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // command items
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ptwa_pkg::OP_W-1:0]            opcode_i,
  input  logic [ptwa_pkg::ADDR_W-1:0]          peer_address_i,
  input  logic [ptwa_pkg::TIME_W-1:0]          now_ms_i,
  input  logic [ptwa_pkg::BYTE_W-1:0]          payload_length_i,
  input  logic [ptwa_pkg::BYTE_W-1:0]          role_byte_i,
  input  logic [ptwa_pkg::HEAD_W-1:0]          name_head_i,
  input  logic [ptwa_pkg::TAIL_W-1:0]          name_tail_i,
  input  logic [ptwa_pkg::BYTE_W-1:0]          cap_5ghz_i,
  input  logic [ptwa_pkg::BYTE_W-1:0]          cap_lowrate_radio_i,
  input  logic [ptwa_pkg::ENTRY_IDX_W-1:0]     entry_index_i,
  // result items
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ptwa_pkg::STATUS_W-1:0]        status_o,
  output logic [ptwa_pkg::TOTAL_W-1:0]         peer_total_o,
  output logic [ptwa_pkg::SLOT_W-1:0]          slot_o,
  output logic [ptwa_pkg::TIME_W-1:0]          newest_age_ms_o,
  output logic [ptwa_pkg::ADDR_W-1:0]          entry_address_o,
  output logic [ptwa_pkg::HEAD_W-1:0]          entry_name_head_o,
  output logic [ptwa_pkg::TAIL_W-1:0]          entry_name_tail_o,
  output logic [ptwa_pkg::BYTE_W-1:0]          entry_cap_5ghz_o,
  output logic [ptwa_pkg::BYTE_W-1:0]          entry_cap_lowrate_o,
  output logic [ptwa_pkg::TIME_W-1:0]          entry_seen_ms_o
);

  logic [ptwa_pkg::TIME_W-1:0] timeout_q;
  logic [ptwa_pkg::BYTE_W-1:0] role_q;

  logic           push_valid, push_ready, pop_valid, pop_ready;
  ptwa_pkg::cmd_t push_data, pop_data;
  ptwa_pkg::res_t res;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= ptwa_pkg::TIMEOUT_RESET;
      role_q    <= ptwa_pkg::ROLE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ptwa_pkg::CFG_TIMEOUT: timeout_q <= cfg_wdata_i[ptwa_pkg::TIME_W-1:0];
        ptwa_pkg::CFG_ROLE:    role_q    <= cfg_wdata_i[ptwa_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify
  ptwa_front u_front (
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .opcode_i            (opcode_i),
    .peer_address_i      (peer_address_i),
    .now_ms_i            (now_ms_i),
    .payload_length_i    (payload_length_i),
    .role_byte_i         (role_byte_i),
    .name_head_i         (name_head_i),
    .name_tail_i         (name_tail_i),
    .cap_5ghz_i          (cap_5ghz_i),
    .cap_lowrate_radio_i (cap_lowrate_radio_i),
    .entry_index_i       (entry_index_i),
    .required_role_i     (role_q),
    .push_valid_o        (push_valid),
    .push_ready_i        (push_ready),
    .push_data_o         (push_data)
  );

  // command queue
  ptwa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // back: table sequencer and output register
  ptwa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .timeout_i   (timeout_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (res)
  );

  assign status_o            = res.status;
  assign peer_total_o        = res.total;
  assign slot_o              = res.slot;
  assign newest_age_ms_o     = res.age;
  assign entry_address_o     = res.addr;
  assign entry_name_head_o   = res.name_head;
  assign entry_name_tail_o   = res.name_tail;
  assign entry_cap_5ghz_o    = res.cap5;
  assign entry_cap_lowrate_o = res.caplr;
  assign entry_seen_ms_o     = res.seen;

endmodule

// ===== rtl/core/ptwa_front.sv =====
module ptwa_front (
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ptwa_pkg::OP_W-1:0]           opcode_i,
  input  logic [ptwa_pkg::ADDR_W-1:0]         peer_address_i,
  input  logic [ptwa_pkg::TIME_W-1:0]         now_ms_i,
  input  logic [ptwa_pkg::BYTE_W-1:0]         payload_length_i,
  input  logic [ptwa_pkg::BYTE_W-1:0]         role_byte_i,
  input  logic [ptwa_pkg::HEAD_W-1:0]         name_head_i,
  input  logic [ptwa_pkg::TAIL_W-1:0]         name_tail_i,
  input  logic [ptwa_pkg::BYTE_W-1:0]         cap_5ghz_i,
  input  logic [ptwa_pkg::BYTE_W-1:0]         cap_lowrate_radio_i,
  input  logic [ptwa_pkg::ENTRY_IDX_W-1:0]    entry_index_i,
  input  logic [ptwa_pkg::BYTE_W-1:0]         required_role_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output ptwa_pkg::cmd_t                      push_data_o
);

  logic [ptwa_pkg::NAME_W-1:0] name_clean;

  assign name_clean   = ptwa_pkg::clean_name({name_tail_i, name_head_i});
  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

  always_comb begin
    push_data_o           = '0;
    push_data_o.op        = ptwa_pkg::op_e'(opcode_i);
    push_data_o.addr      = peer_address_i;
    push_data_o.now       = now_ms_i;
    // length and role gate for hellos
    push_data_o.hello_ok  = (payload_length_i >= ptwa_pkg::BYTE_W'(ptwa_pkg::HELLO_MIN_BYTES))
                            && (role_byte_i == required_role_i);
    push_data_o.name_head = name_clean[ptwa_pkg::HEAD_W-1:0];
    push_data_o.name_tail = name_clean[ptwa_pkg::NAME_W-1:ptwa_pkg::HEAD_W];
    push_data_o.cap5      = cap_5ghz_i;
    push_data_o.caplr     = cap_lowrate_radio_i;
    push_data_o.ridx      = entry_index_i;
  end

endmodule

// ===== rtl/core/ptwa_fifo.sv =====
module ptwa_fifo #(
  parameter int unsigned DEPTH = ptwa_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  ptwa_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output ptwa_pkg::cmd_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  ptwa_pkg::cmd_t    mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              do_push, do_pop;

  assign push_ready_o = (fill_q != FILL_W'(DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/ptwa_back.sv =====
module ptwa_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  ptwa_pkg::cmd_t              pop_data_i,
  input  logic [ptwa_pkg::TIME_W-1:0] timeout_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ptwa_pkg::res_t              out_data_o
);

  localparam int unsigned SLOTS = ptwa_pkg::TABLE_SLOTS;
  localparam int unsigned IDX_W = ptwa_pkg::IDX_W;
  localparam int unsigned CNT_W = ptwa_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_WALK = 6'b000100,
    S_COPY = 6'b001000,
    S_SCAN = 6'b010000,
    S_DONE = 6'b100000
  } back_state_e;

  // peer stores, valid below occ_q only
  logic [ptwa_pkg::ADDR_W-1:0] addr_q  [SLOTS];
  logic [ptwa_pkg::HEAD_W-1:0] head_q  [SLOTS];
  logic [ptwa_pkg::TAIL_W-1:0] tail_q  [SLOTS];
  logic [ptwa_pkg::TIME_W-1:0] seen_q  [SLOTS];
  logic [ptwa_pkg::BYTE_W-1:0] cap5_q  [SLOTS];
  logic [ptwa_pkg::BYTE_W-1:0] caplr_q [SLOTS];

  back_state_e                 state_q, state_d;
  logic [CNT_W-1:0]            occ_q, occ_d;
  logic [CNT_W-1:0]            k_q, k_d;
  logic [IDX_W-1:0]            cur_q, cur_d;
  logic [ptwa_pkg::TIME_W-1:0] best_q, best_d;
  ptwa_pkg::cmd_t              cmd_q, cmd_d;
  ptwa_pkg::res_t              res_q, res_d;
  ptwa_pkg::res_t              out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  // lookup
  logic [SLOTS-1:0]            hit;
  logic                        hit_any;
  logic [IDX_W-1:0]            hit_idx;
  logic [IDX_W-1:0]            last_idx;

  // single read port
  logic [IDX_W-1:0]            rd_idx;
  logic [ptwa_pkg::TIME_W-1:0] age_cur;

  // single write port with per-group enables
  logic                        we_addr, we_info, we_seen;
  logic [IDX_W-1:0]            wr_idx;
  logic [ptwa_pkg::ADDR_W-1:0] wr_addr;
  logic [ptwa_pkg::HEAD_W-1:0] wr_head;
  logic [ptwa_pkg::TAIL_W-1:0] wr_tail;
  logic [ptwa_pkg::TIME_W-1:0] wr_seen;
  logic [ptwa_pkg::BYTE_W-1:0] wr_cap5, wr_caplr;

  assign last_idx = IDX_W'(occ_q - CNT_W'(1));
  assign age_cur  = cmd_q.now - seen_q[rd_idx];

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = (CNT_W'(i) < occ_q) && (addr_q[i] == cmd_q.addr);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
    hit_any = |hit;
  end

  assign pop_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    k_d         = k_q;
    cur_d       = cur_q;
    best_d      = best_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rd_idx      = IDX_W'(cmd_q.ridx);
    we_addr     = 1'b0;
    we_info     = 1'b0;
    we_seen     = 1'b0;
    wr_idx      = hit_idx;
    wr_addr     = cmd_q.addr;
    wr_head     = cmd_q.name_head;
    wr_tail     = cmd_q.name_tail;
    wr_seen     = cmd_q.now;
    wr_cap5     = cmd_q.cap5;
    wr_caplr    = cmd_q.caplr;

    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          cmd_d   = pop_data_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d   = '0;
        state_d = S_DONE;
        case (cmd_q.op)
          ptwa_pkg::OP_HELLO: begin
            if (!cmd_q.hello_ok) begin
              res_d.status = ptwa_pkg::ST_IGNORED;
            end else if (hit_any) begin
              we_info      = 1'b1;
              we_seen      = 1'b1;
              res_d.status = ptwa_pkg::ST_UPDATED;
              res_d.slot   = ptwa_pkg::SLOT_W'(hit_idx);
            end else if (occ_q < CNT_W'(SLOTS)) begin
              // append at the end of the table
              wr_idx       = IDX_W'(occ_q);
              we_addr      = 1'b1;
              we_info      = 1'b1;
              we_seen      = 1'b1;
              occ_d        = occ_q + CNT_W'(1);
              res_d.status = ptwa_pkg::ST_INSERTED;
              res_d.slot   = ptwa_pkg::SLOT_W'(IDX_W'(occ_q));
            end else begin
              res_d.status = ptwa_pkg::ST_FULL;
            end
          end
          ptwa_pkg::OP_PONG: begin
            if (hit_any) begin
              we_seen      = 1'b1;
              res_d.status = ptwa_pkg::ST_UPDATED;
              res_d.slot   = ptwa_pkg::SLOT_W'(hit_idx);
            end else begin
              res_d.status = ptwa_pkg::ST_UNKNOWN;
            end
          end
          ptwa_pkg::OP_READ: begin
            if (CNT_W'(cmd_q.ridx) >= occ_q) begin
              res_d.status = ptwa_pkg::ST_BAD_INDEX;
            end else begin
              res_d.status    = ptwa_pkg::ST_UPDATED;
              res_d.addr      = addr_q[rd_idx];
              res_d.name_head = head_q[rd_idx];
              res_d.name_tail = tail_q[rd_idx];
              res_d.cap5      = cap5_q[rd_idx];
              res_d.caplr     = caplr_q[rd_idx];
              res_d.seen      = seen_q[rd_idx];
            end
          end
          ptwa_pkg::OP_QUERY: begin
            cur_d  = last_idx;
            k_d    = '0;
            best_d = '0;
            state_d = (occ_q == '0) ? S_SCAN : S_WALK;
          end
          default: begin
            res_d.status = ptwa_pkg::ST_IGNORED;
          end
        endcase
        res_d.total = ptwa_pkg::TOTAL_W'(occ_d);
      end

      // downward eviction walk
      S_WALK: begin
        rd_idx = cur_q;
        if (age_cur > timeout_i) begin
          state_d = S_COPY;
        end else if (cur_q == '0) begin
          state_d = S_SCAN;
        end else begin
          cur_d = cur_q - IDX_W'(1);
        end
      end

      // evicted slot takes the current last entry
      S_COPY: begin
        rd_idx   = last_idx;
        wr_idx   = cur_q;
        we_addr  = 1'b1;
        we_info  = 1'b1;
        we_seen  = 1'b1;
        wr_addr  = addr_q[rd_idx];
        wr_head  = head_q[rd_idx];
        wr_tail  = tail_q[rd_idx];
        wr_seen  = seen_q[rd_idx];
        wr_cap5  = cap5_q[rd_idx];
        wr_caplr = caplr_q[rd_idx];
        occ_d    = occ_q - CNT_W'(1);
        if (cur_q == '0) begin
          state_d = S_SCAN;
        end else begin
          cur_d   = cur_q - IDX_W'(1);
          state_d = S_WALK;
        end
      end

      // newest last-seen over the survivors
      S_SCAN: begin
        rd_idx = IDX_W'(k_q);
        if (k_q == occ_q) begin
          res_d        = '0;
          res_d.status = ptwa_pkg::ST_UPDATED;
          res_d.total  = ptwa_pkg::TOTAL_W'(occ_q);
          res_d.age    = (best_q == '0) ? '1 : cmd_q.now - best_q;
          state_d      = S_DONE;
        end else begin
          if (seen_q[rd_idx] > best_q) begin
            best_d = seen_q[rd_idx];
          end
          k_d = k_q + CNT_W'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    cur_q  <= cur_d;
    best_q <= best_d;
    cmd_q  <= cmd_d;
    res_q  <= res_d;
    out_q  <= out_d;
    if (we_addr) begin
      addr_q[wr_idx] <= wr_addr;
    end
    if (we_info) begin
      head_q[wr_idx]  <= wr_head;
      tail_q[wr_idx]  <= wr_tail;
      cap5_q[wr_idx]  <= wr_cap5;
      caplr_q[wr_idx] <= wr_caplr;
    end
    if (we_seen) begin
      seen_q[wr_idx] <= wr_seen;
    end
  end

endmodule

// ===== rtl/core/ptwa_checker.sv =====
`include "peer_table_with_aging_macros.svh"

module ptwa_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [ptwa_pkg::STATUS_W-1:0]        status_o,
  input logic [ptwa_pkg::TOTAL_W-1:0]         peer_total_o,
  input logic [ptwa_pkg::SLOT_W-1:0]          slot_o,
  input logic [ptwa_pkg::TIME_W-1:0]          newest_age_ms_o,
  input logic [ptwa_pkg::ADDR_W-1:0]          entry_address_o,
  input logic [ptwa_pkg::TIME_W-1:0]          entry_seen_ms_o
);

  // stalled result holds
  `PTWA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(peer_total_o) && $stable(newest_age_ms_o))

  // count never exceeds the table
  `PTWA_ASSERT_IMPL(a_total_range, out_valid_o, peer_total_o <= ptwa_pkg::TOTAL_W'(ptwa_pkg::TABLE_SLOTS))

  // an insert lands in the last occupied slot
  `PTWA_ASSERT_IMPL(a_insert_slot, out_valid_o && (status_o == ptwa_pkg::ST_INSERTED), ({1'b0, slot_o} == (peer_total_o - 3'd1)) && (peer_total_o != 3'd0))

  // bad index returns a blank entry
  `PTWA_ASSERT_IMPL(a_bad_index_blank, out_valid_o && (status_o == ptwa_pkg::ST_BAD_INDEX), (entry_address_o == '0) && (entry_seen_ms_o == '0) && (slot_o == '0))

  // rejected hellos and unknown pongs touch no slot
  `PTWA_ASSERT_IMPL(a_reject_no_slot, out_valid_o && ((status_o == ptwa_pkg::ST_IGNORED) || (status_o == ptwa_pkg::ST_FULL) || (status_o == ptwa_pkg::ST_UNKNOWN)), (slot_o == '0) && (newest_age_ms_o == '0))

endmodule

bind peer_table_with_aging ptwa_checker u_ptwa_checker (.*);
